@@ src/fuel_level_estimator_autocal_core_macros.svh @@
// Assertion helpers for the fuel level estimator
`ifndef FUEL_LEVEL_ESTIMATOR_AUTOCAL_CORE_MACROS_SVH
`define FUEL_LEVEL_ESTIMATOR_AUTOCAL_CORE_MACROS_SVH

// Property that holds at every clock edge outside reset
`define FLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property that must also hold while reset is low
`define FLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ src/fle_pkg.sv @@
package fle_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 18;

    localparam logic [CfgIdxW-1:0] CFG_TANK = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RPM = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KMIN = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KMAX = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LRATE = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_DEAD = 3'd5;

    localparam logic [15:0] TANK_RST = 16'd50000;
    localparam logic [13:0] RPM_RST = 14'd100;
    localparam logic [17:0] KMIN_RST = 18'd45875;
    localparam logic [17:0] KMAX_RST = 18'd85197;
    localparam logic [15:0] LRATE_RST = 16'd13107;
    localparam logic [15:0] DEAD_RST = 16'd1966;
    localparam logic [17:0] K_ONE = 18'd65536;

    // width of the shared serial divider
    localparam int DivNW = 56;
    localparam int DivDW = 38;
    localparam int DivCW = 6;

    localparam int InW = 72;
    localparam int OutW = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_DIV,
        ST_TICK_APPLY,
        ST_ODO_DIV,
        ST_ODO_APPLY,
        ST_KRAW_DIV,
        ST_DEAD_MUL,
        ST_DELTA_MUL,
        ST_K_APPLY,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic [DivNW-1:0] num;
        logic [DivDW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic [DivNW-1:0] quo;
    } t_div_rsp;

endpackage

@@ src/fle_serdiv.sv @@
// Restoring divider, one quotient bit per cycle.
module fle_serdiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fle_pkg::t_div_req   i_req,
    output fle_pkg::t_div_rsp   o_rsp
);
    logic [fle_pkg::DivNW-1:0] r_quo, n_quo;
    logic [fle_pkg::DivDW:0]   r_rem, n_rem;
    logic [fle_pkg::DivDW-1:0] r_den, n_den;
    logic [fle_pkg::DivCW-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [fle_pkg::DivDW:0] w_sh;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh = '0;
        if (i_req.start) begin
            n_quo = i_req.num;
            n_den = i_req.den;
            n_rem = '0;
            n_cnt = fle_pkg::DivCW'(fle_pkg::DivNW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            w_sh = {r_rem[fle_pkg::DivDW-1:0], r_quo[fle_pkg::DivNW-1]};
            n_quo = {r_quo[fle_pkg::DivNW-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_sh;
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_quo;
endmodule

@@ src/fuel_level_estimator_autocal_core.sv @@
// Channel   | Dir | Payload (low bit first)
// s_axis    | in  | tuser kind; tdata rpm14 rate18 refuel17 full1 miles20
// m_axis    | out | tdata fuel16 k18 needcal1 km21 refset1
// cfg       | in  | i_cfg_we / i_cfg_idx / i_cfg_data, one register per write
// Steps: a tick above threshold runs one 56-step serial divide, then applies it; a
// tick below threshold or a partial refuel goes straight to output; a full refuel
// divides, and to learn the factor divides again, then the dead-zone check and update.
// Reset: synchronous, active low; config and state registers return to their defaults.
// Stalls: result waits in the output register; next item accepted once taken.
module fuel_level_estimator_autocal_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // rpm, rate, refuel_ml, full_tank, miles
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // fuel, factor, needs_cal, km, ref_set, pad
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [17:0] i_cfg_data
);
    // configuration
    logic [15:0] r_tank, r_lrate, r_dead;
    logic [13:0] r_rpm_th;
    logic [17:0] r_kmin, r_kmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tank <= fle_pkg::TANK_RST;
            r_rpm_th <= fle_pkg::RPM_RST;
            r_kmin <= fle_pkg::KMIN_RST;
            r_kmax <= fle_pkg::KMAX_RST;
            r_lrate <= fle_pkg::LRATE_RST;
            r_dead <= fle_pkg::DEAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fle_pkg::CFG_TANK:  r_tank <= i_cfg_data[15:0];
                fle_pkg::CFG_RPM:   r_rpm_th <= i_cfg_data[13:0];
                fle_pkg::CFG_KMIN:  r_kmin <= i_cfg_data;
                fle_pkg::CFG_KMAX:  r_kmax <= i_cfg_data;
                fle_pkg::CFG_LRATE: r_lrate <= i_cfg_data[15:0];
                fle_pkg::CFG_DEAD:  r_dead <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [13:0] w_rpm;
    logic [17:0] w_rate;
    logic [16:0] w_ml;
    logic        w_full;
    logic [19:0] w_miles;
    assign w_rpm = s_axis_tdata[13:0];
    assign w_rate = s_axis_tdata[31:14];
    assign w_ml = s_axis_tdata[48:32];
    assign w_full = s_axis_tdata[49];
    assign w_miles = s_axis_tdata[69:50];

    // state
    fle_pkg::t_state r_st, n_st;
    logic [15:0] r_level, n_level;
    logic [17:0] r_k, n_k;
    logic [39:0] r_use, n_use;
    logic [19:0] r_refd, n_refd;
    logic r_ref, n_ref, r_ncal, n_ncal;
    logic [20:0] r_km, n_km;
    // item latches and scratch
    logic [17:0] r_rate, n_rate;
    logic [20:0] r_real, n_real;
    logic [39:0] r_tmp, n_tmp;
    logic        r_up, n_up;
    logic [63:0] r_out, n_out;
    logic        r_ov, n_ov;

    fle_pkg::t_div_req w_req;
    fle_pkg::t_div_rsp w_rsp;
    fle_serdiv u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic [40:0] w_usesum;
    logic [20:0] w_refsum, w_realsum;
    logic [17:0] w_lvlsum;
    logic [35:0] w_prod;
    logic [17:0] w_kraw;
    logic [51:0] w_dprod;
    logic [35:0] w_delta;
    logic [36:0] w_ksum;

    always_comb begin
        n_st = r_st;
        n_level = r_level; n_k = r_k; n_use = r_use; n_refd = r_refd;
        n_ref = r_ref; n_ncal = r_ncal; n_km = r_km;
        n_rate = r_rate; n_real = r_real; n_tmp = r_tmp; n_up = r_up;
        n_out = r_out; n_ov = r_ov;
        w_req = '0;
        w_usesum = '0; w_refsum = '0; w_realsum = '0; w_lvlsum = '0;
        w_prod = '0; w_kraw = '0; w_dprod = '0; w_delta = '0; w_ksum = '0;
        s_axis_tready = (r_st == fle_pkg::ST_IDLE) && !r_ov;
        if (r_ov && m_axis_tready) n_ov = 1'b0;
        case (r_st)
            fle_pkg::ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (!s_axis_tuser) begin
                        if (w_rpm > r_rpm_th) begin
                            n_rate = w_rate;
                            // rate*K fits 36 bits; K by multiply before divide
                            w_prod = w_rate * r_k;
                            w_req.start = 1'b1;
                            w_req.num = 56'(w_prod);
                            w_req.den = 38'(32'd235929600);
                            n_st = fle_pkg::ST_TICK_DIV;
                        end else begin
                            n_st = fle_pkg::ST_OUT;
                        end
                    end else if (!w_full) begin
                        w_lvlsum = {2'b0, r_level} + {1'b0, w_ml};
                        if (w_lvlsum > {2'b0, r_tank}) begin
                            n_level = r_tank;
                            n_ncal = 1'b1;
                        end else begin
                            n_level = w_lvlsum[15:0];
                        end
                        w_refsum = {1'b0, r_refd} + w_ml;
                        n_refd = w_refsum[20] ? '1 : w_refsum[19:0];
                        n_st = fle_pkg::ST_OUT;
                    end else begin
                        w_realsum = {1'b0, r_refd} + {4'd0, w_ml};
                        n_real = w_realsum;
                        n_up = r_ref && (w_realsum != '0) && (r_use != '0);
                        w_req.start = 1'b1;
                        w_req.num = 56'(w_miles * 18'd160934);
                        w_req.den = 38'd100000;
                        n_st = fle_pkg::ST_ODO_DIV;
                    end
                end
            end
            fle_pkg::ST_TICK_DIV: begin
                if (w_rsp.done) n_st = fle_pkg::ST_TICK_APPLY;
            end
            fle_pkg::ST_TICK_APPLY: begin
                if (w_rsp.quo[55:16] == '0 && r_level >= w_rsp.quo[15:0]) begin
                    n_level = r_level - w_rsp.quo[15:0];
                end else begin
                    n_level = '0;
                    n_ncal = 1'b1;
                end
                w_usesum = {1'b0, r_use} + r_rate;
                n_use = w_usesum[40] ? '1 : w_usesum[39:0];
                n_st = fle_pkg::ST_OUT;
            end
            fle_pkg::ST_ODO_DIV: begin
                if (w_rsp.done) n_st = fle_pkg::ST_ODO_APPLY;
            end
            fle_pkg::ST_ODO_APPLY: begin
                n_km = w_rsp.quo[20:0];
                if (r_up) begin
                    w_req.start = 1'b1;
                    w_req.num = {r_use, 16'd0};
                    w_req.den = 38'(r_real * 12'd3600);
                    n_st = fle_pkg::ST_KRAW_DIV;
                end else begin
                    n_st = fle_pkg::ST_K_APPLY;
                    n_tmp = '0;
                    n_rate = '0;
                end
            end
            fle_pkg::ST_KRAW_DIV: begin
                if (w_rsp.done) begin
                    // large ratios saturate; clamp then decides anyway
                    n_tmp = (w_rsp.quo[55:35] != '0) ? 40'h8_0000_0000
                                                     : {5'd0, w_rsp.quo[34:0]};
                    n_st = fle_pkg::ST_DEAD_MUL;
                end
            end
            fle_pkg::ST_DEAD_MUL: begin
                // r_tmp: kraw; build |kraw-k| and direction
                if (r_tmp >= {22'd0, r_k}) begin
                    n_tmp = r_tmp - {22'd0, r_k};
                    n_up = 1'b1;
                end else begin
                    n_tmp = {22'd0, r_k} - r_tmp;
                    n_up = 1'b0;
                end
                n_st = fle_pkg::ST_DELTA_MUL;
            end
            fle_pkg::ST_DELTA_MUL: begin
                // dead zone: diff*65536 < dead*K  <=>  diff < ceil(dead*K/65536)
                w_prod = r_dead * r_k;
                if ({r_tmp, 16'd0} < {20'd0, w_prod}) begin
                    n_st = fle_pkg::ST_OUT;
                    n_tmp = '0;
                end else begin
                    n_st = fle_pkg::ST_K_APPLY;
                    n_rate = 18'h1; // marks learning pending
                end
            end
            fle_pkg::ST_K_APPLY: begin
                if (r_rate == 18'h1) begin
                    // diff stays below 2^36, so the full delta is kept
                    w_dprod = r_tmp[35:0] * r_lrate;
                    w_delta = w_dprod[51:16];
                    if (r_up) begin
                        w_ksum = {19'd0, r_k} + {1'b0, w_delta};
                        w_kraw = (w_ksum[36:18] != '0) ? 18'h3FFFF : w_ksum[17:0];
                    end else begin
                        w_kraw = (w_delta > {18'd0, r_k}) ? 18'd0
                                                          : r_k - w_delta[17:0];
                    end
                    if (w_kraw < r_kmin) w_kraw = r_kmin;
                    if (w_kraw > r_kmax) w_kraw = r_kmax;
                    n_k = w_kraw;
                end
                n_use = '0;
                n_refd = '0;
                n_level = r_tank;
                n_ref = 1'b1;
                n_ncal = 1'b0;
                n_rate = '0;
                n_st = fle_pkg::ST_OUT;
            end
            fle_pkg::ST_OUT: begin
                if (!r_ov || m_axis_tready) begin
                    n_out = {7'd0, r_ref, r_km, r_ncal, r_k, r_level};
                    n_ov = 1'b1;
                    n_st = fle_pkg::ST_IDLE;
                end
            end
            default: n_st = fle_pkg::ST_IDLE;
        endcase
        // dead zone skip path still must finish the full-fill bookkeeping
        if (r_st == fle_pkg::ST_DELTA_MUL && n_st == fle_pkg::ST_OUT) begin
            n_use = '0; n_refd = '0; n_level = r_tank;
            n_ref = 1'b1; n_ncal = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= fle_pkg::ST_IDLE;
            r_level <= '0;
            r_k <= fle_pkg::K_ONE;
            r_use <= '0;
            r_refd <= '0;
            r_ref <= 1'b0;
            r_ncal <= 1'b0;
            r_km <= '0;
            r_ov <= 1'b0;
            r_rate <= '0;
        end else begin
            r_st <= n_st;
            r_level <= n_level;
            r_k <= n_k;
            r_use <= n_use;
            r_refd <= n_refd;
            r_ref <= n_ref;
            r_ncal <= n_ncal;
            r_km <= n_km;
            r_ov <= n_ov;
            r_rate <= n_rate;
        end
        r_real <= n_real;
        r_tmp <= n_tmp;
        r_up <= n_up;
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;
endmodule

@@ src/fle_checker.sv @@
`include "fuel_level_estimator_autocal_core_macros.svh"
module fle_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    `FLE_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
    `FLE_ASSERT(a_no_take_busy, m_axis_tvalid |-> !s_axis_tready, "input taken while result pending")
    `FLE_ASSERT(a_pad, m_axis_tvalid |-> m_axis_tdata[63:57] == 7'd0, "pad bits set")
    `FLE_ASSERT_ALWAYS(a_rst, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
endmodule

bind fuel_level_estimator_autocal_core fle_port_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

@@ bench/fle_checker.sv @@
module fle_checker
    import fle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [17:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        ref_set;
        logic [20:0] km;
        logic        need_cal;
        logic [17:0] factor;
        logic [15:0] fuel;
    } t_status;

    localparam logic [39:0] USE_SAT = '1;
    localparam logic [19:0] FILL_SAT = '1;

    // configuration copy
    logic [15:0] tank_cap;
    logic [13:0] rpm_thr;
    logic [17:0] k_min, k_max;
    logic [15:0] l_rate, dz;
    // tracked state
    logic [15:0] level;
    logic [17:0] k_cur;
    logic [39:0] use_acc;
    logic [19:0] fill_acc;
    logic        have_ref, need_cal;
    logic [20:0] km_cur;

    t_status status_q[$];

    task automatic learn_k(input logic [63:0] real_ml);
        logic [63:0] kraw, diff, capped, delta, knew;
        logic        up;
        kraw = ({24'd0, use_acc} << 16) / (64'd3600 * real_ml);
        up = kraw >= k_cur;
        diff = up ? kraw - k_cur : k_cur - kraw;
        capped = (diff > (64'd1 << 34)) ? (64'd1 << 34) : diff;
        if ((capped << 16) < 64'(dz) * 64'(k_cur)) return;
        if (diff > (64'd1 << 40)) diff = 64'd1 << 40;
        delta = (diff * l_rate) >> 16;
        knew = up ? k_cur + delta : k_cur - delta;
        if (knew < k_min) knew = k_min;
        if (knew > k_max) knew = k_max;
        k_cur = knew[17:0];
    endtask

    task automatic predict_status(input logic kind, input logic [71:0] d);
        logic [13:0] rpm;
        logic [17:0] rate;
        logic [16:0] add_ml;
        logic        full;
        logic [19:0] miles;
        logic [63:0] burn, sum;
        t_status     s;
        rpm = d[13:0];
        rate = d[31:14];
        add_ml = d[48:32];
        full = d[49];
        miles = d[69:50];
        if (!kind) begin
            if (rpm > rpm_thr) begin
                burn = (64'(rate) * k_cur) / (64'd3600 * 64'd65536);
                if (64'(level) >= burn) begin
                    level = level - burn[15:0];
                end else begin
                    level = '0;
                    need_cal = 1'b1;
                end
                sum = 64'(use_acc) + rate;
                use_acc = (sum > USE_SAT) ? USE_SAT : sum[39:0];
            end
        end else if (full) begin
            km_cur = 21'((64'(miles) * 160934) / 100000);
            sum = 64'(fill_acc) + add_ml;
            if (have_ref && sum > 0 && use_acc > 0) learn_k(sum);
            fill_acc = '0;
            use_acc = '0;
            level = tank_cap;
            have_ref = 1'b1;
            need_cal = 1'b0;
        end else begin
            sum = 64'(level) + add_ml;
            if (sum > tank_cap) begin
                level = tank_cap;
                need_cal = 1'b1;
            end else begin
                level = sum[15:0];
            end
            sum = 64'(fill_acc) + add_ml;
            fill_acc = (sum > FILL_SAT) ? FILL_SAT : sum[19:0];
        end
        s.fuel = level;
        s.factor = k_cur;
        s.need_cal = need_cal;
        s.km = km_cur;
        s.ref_set = have_ref;
        status_q.push_back(s);
    endtask

    always @(posedge i_clk) begin
        t_status want, got;
        if (!i_rst_n) begin
            tank_cap <= TANK_RST;
            rpm_thr <= RPM_RST;
            k_min <= KMIN_RST;
            k_max <= KMAX_RST;
            l_rate <= LRATE_RST;
            dz <= DEAD_RST;
            level = '0;
            k_cur = K_ONE;
            use_acc = '0;
            fill_acc = '0;
            have_ref = 1'b0;
            need_cal = 1'b0;
            km_cur = '0;
            o_fail_count <= 0;
            o_results <= 0;
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TANK:  tank_cap <= i_cfg_data[15:0];
                    CFG_RPM:   rpm_thr <= i_cfg_data[13:0];
                    CFG_KMIN:  k_min <= i_cfg_data;
                    CFG_KMAX:  k_max <= i_cfg_data;
                    CFG_LRATE: l_rate <= i_cfg_data[15:0];
                    CFG_DEAD:  dz <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[56:0];
                o_results <= o_results + 1;
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch exp fuel %0d k %0d nc %0b km %0d ref %0b",
                                 $time, want.fuel, want.factor, want.need_cal, want.km,
                                 want.ref_set);
                        $display("%0t:          got fuel %0d k %0d nc %0b km %0d ref %0b",
                                 $time, got.fuel, got.factor, got.need_cal, got.km,
                                 got.ref_set);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_status(s_axis_tuser, s_axis_tdata);
        end
        o_pending <= status_q.size();
    end
endmodule

@@ bench/tb_top.sv @@
module tb_top;
    import fle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // rpm14, rate18, refuel17, full1, miles20, pad
    logic        s_axis_tuser = 1'b0; // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // fuel16, k18, needcal1, km21, refset1, pad
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [17:0] i_cfg_data = '0;

    int  fail_count, pending, results;
    int  idle_cycles;
    bit  calm;        // no idling on either side while set
    int  n_ticks, n_partial, n_full;

    always #1 i_clk = ~i_clk;

    fuel_level_estimator_autocal_core dut (.*);

    fle_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    // receiver stalls ~27% unless calm
    always @(posedge i_clk)
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // the block is busy once it accepts an item, so waiting on the clock after
    // dropping valid costs no throughput
    task automatic send_item(input logic kind, input logic [13:0] rpm,
                             input logic [17:0] rate, input logic [16:0] ml,
                             input logic full, input logic [19:0] miles);
        while (!calm && $urandom_range(99) < 27) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {2'b00, miles, full, ml, rate, rpm};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        if (kind && full) n_full++;
        else if (kind) n_partial++;
        else n_ticks++;
    endtask

    // wait for every result, then let the longest operation finish
    task automatic drain;
        while (pending != 0 || s_axis_tvalid) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] tank, input logic [13:0] rpm,
                            input logic [17:0] kmin, input logic [17:0] kmax,
                            input logic [15:0] lr, input logic [15:0] dzone);
        write_reg(CFG_TANK, 18'(tank));
        write_reg(CFG_RPM, 18'(rpm));
        write_reg(CFG_KMIN, kmin);
        write_reg(CFG_KMAX, kmax);
        write_reg(CFG_LRATE, 18'(lr));
        write_reg(CFG_DEAD, 18'(dzone));
    endtask

    // random item: mostly drive cycles with occasional top-ups and full fills
    task automatic random_item(input int lo_rate);
        int r;
        r = $urandom_range(99);
        if (r < 80)
            send_item(1'b0, ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(300)),
                      ($urandom_range(15) == 0) ? 18'($urandom)
                                                : 18'($urandom_range(60000, lo_rate)),
                      17'($urandom), 1'($urandom), 20'($urandom));
        else if (r < 92)
            send_item(1'b1, 14'($urandom), 18'($urandom),
                      ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(3000)),
                      1'b0, 20'($urandom));
        else
            send_item(1'b1, 14'($urandom), 18'($urandom),
                      ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(20)),
                      1'b1, 20'($urandom));
    endtask

    initial begin
        calm = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, extremes of each field, both refuel kinds
        send_item(1'b0, 14'h3FFF, 18'h3FFFF, '0, 1'b0, '0);    // tick on empty tank
        send_item(1'b1, '0, '0, 17'd0, 1'b0, '0);              // zero top-up
        send_item(1'b1, '0, '0, 17'h1FFFF, 1'b0, '0);          // overflow top-up
        send_item(1'b1, '0, '0, 17'd5, 1'b1, 20'hFFFFF);       // first reference fill
        send_item(1'b0, 14'd100, 18'd50000, '0, 1'b0, '0);     // rpm at threshold
        send_item(1'b0, 14'd101, 18'h3FFFF, '0, 1'b0, '0);
        send_item(1'b0, 14'd101, 18'h3FFFF, '0, 1'b0, '0);
        send_item(1'b1, '0, '0, 17'd1000, 1'b0, '0);
        send_item(1'b1, '0, '0, 17'd10, 1'b1, 20'd0);          // learning fill
        send_item(1'b1, '0, '0, 17'd0, 1'b1, 20'd12345);       // nothing used
        send_item(1'b0, 14'd5000, 18'd1, '0, 1'b0, '0);
        send_item(1'b1, '0, '0, 17'h1FFFF, 1'b1, 20'd1);       // tiny ratio
        drain();

        // capacity below level, max beats min, full learning rate
        set_regs(16'd1, 14'd0, 18'h3FFFF, 18'd0, 16'hFFFF, 16'd0);
        send_item(1'b1, '0, '0, 17'd0, 1'b0, '0);
        send_item(1'b0, 14'd1, 18'h3FFFF, '0, 1'b0, '0);
        send_item(1'b1, '0, '0, 17'd1, 1'b1, 20'd7);
        send_item(1'b0, 14'h3FFF, 18'd0, '0, 1'b0, '0);
        send_item(1'b1, '0, '0, 17'd1, 1'b1, 20'd7);
        drain();

        // random phases across several settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_regs(16'd50000, 14'd100, 18'd45875, 18'd85197, 16'd13107, 16'd1966);
                1: set_regs(16'hFFFF, 14'h3FFF, 18'd0, 18'h3FFFF, 16'hFFFF, 16'hFFFF);
                2: set_regs(16'd1, 14'd0, 18'd0, 18'd0, 16'd0, 16'd0);
                3: set_regs(16'($urandom_range(65535, 1)), 14'($urandom_range(300)),
                            18'($urandom_range(70000)), 18'($urandom_range(262143, 60000)),
                            16'($urandom), 16'($urandom_range(4000)));
                default: set_regs(16'd30000, 14'd50, 18'd40000, 18'd120000, 16'd30000,
                                  16'd500);
            endcase
            calm = (phase == 1);
            for (int i = 0; i < 185; i++) begin
                random_item((phase == 4) ? 20000 : 0);
                if (i == 90) begin
                    // sender holds off until the block has caught up
                    while (pending != 0) @(posedge i_clk);
                end
            end
            calm = 1'b0;
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("Covered %0d ticks, %0d top-ups, %0d full fills; %0d results checked.",
                 n_ticks, n_partial, n_full, results);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+src
src/fle_pkg.sv
src/fle_serdiv.sv
src/fuel_level_estimator_autocal_core.sv
src/fle_checker.sv
bench/fle_checker.sv
bench/tb_top.sv
